@@ sv/twd_pkg.sv @@
package twd_pkg;

  localparam int NodeCount = 4096;
  localparam int NodeW     = $clog2(NodeCount);
  localparam int PoolW     = NodeW + 1;
  localparam int AlphaSize = 27;
  localparam int BranchW   = $clog2(AlphaSize + 1);
  localparam int CountW    = 20;

  localparam logic [7:0]         ApostropheCode   = 8'd39;
  localparam logic [BranchW-1:0] ApostropheBranch = BranchW'(26);
  localparam logic [BranchW-1:0] NoBranch         = BranchW'(AlphaSize);

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHAR  = 2'd1;
  localparam logic [1:0] STATUS_POOL_FULL = 2'd2;

  typedef logic [NodeW-1:0] node_t;

  // The end mark of a node lives in the slot of its parent that points to it.
  typedef struct packed {
    logic  end_mark;
    node_t child;
  } entry_t;

  typedef entry_t [AlphaSize-1:0] row_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
    logic       last_char;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [1:0]        status;
    logic [CountW-1:0] word_count;
  } result_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic exec;
    logic clr_we;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_stat_t;

  function automatic logic [BranchW-1:0] branch_of(logic [7:0] c);
    logic [7:0] diff;
    diff = 8'h00;
    if (c inside {[8'h41:8'h5A]}) begin
      diff = c - 8'h41;
      return diff[BranchW-1:0];
    end else if (c inside {[8'h61:8'h7A]}) begin
      diff = c - 8'h61;
      return diff[BranchW-1:0];
    end else if (c == ApostropheCode) begin
      return ApostropheBranch;
    end
    return NoBranch;
  endfunction

endpackage

@@ sv/twd_ctrl.sv @@
module twd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  twd_pkg::dp_stat_t     stat,
  output logic                  busy,
  output twd_pkg::ctrl_cmd_t    cmd
);

  twd_pkg::state_t state;
  twd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= twd_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      twd_pkg::ST_CLEAR: begin
        if (stat.clr_last) state_next = twd_pkg::ST_IDLE;
      end
      twd_pkg::ST_IDLE: begin
        if (start) state_next = twd_pkg::ST_EXEC;
      end
      twd_pkg::ST_EXEC: begin
        state_next = twd_pkg::ST_IDLE;
      end
      default: begin
        state_next = twd_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    cmd.rd_en  = 1'b0;
    cmd.exec   = 1'b0;
    cmd.clr_we = 1'b0;
    case (state)
      twd_pkg::ST_CLEAR: begin
        cmd.clr_we = 1'b1;
      end
      twd_pkg::ST_IDLE: begin
        busy      = 1'b0;
        cmd.rd_en = start;
      end
      twd_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

@@ sv/twd_datapath.sv @@
module twd_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  twd_pkg::item_t        item,
  input  twd_pkg::ctrl_cmd_t    cmd,
  output twd_pkg::dp_stat_t     stat,
  output logic                  done,
  output twd_pkg::result_t      result
);

  // One row per node holds all of its branches.
  twd_pkg::row_t mem [twd_pkg::NodeCount];

  twd_pkg::row_t                     rd_row;
  twd_pkg::item_t                    cur_item;
  twd_pkg::node_t                    cursor;
  logic [twd_pkg::PoolW-1:0]         next_free;
  logic                              miss;
  logic                              bad;
  logic [twd_pkg::CountW-1:0]        words;
  twd_pkg::node_t                    clr_cnt;

  logic [twd_pkg::BranchW-1:0]       br;
  logic [twd_pkg::BranchW-1:0]       br_idx;
  logic                              br_ok;
  twd_pkg::entry_t                   entry;
  logic                              have;
  logic                              walk;
  logic                              alloc;
  logic                              full;
  logic                              miss_set;
  logic                              moved;
  logic                              ok_final;
  logic                              mark;
  logic                              row_we;
  twd_pkg::node_t                    reached;
  twd_pkg::entry_t                   entry_new;
  twd_pkg::row_t                     row_new;

  assign stat.clr_last = (clr_cnt == '1);

  always_comb begin
    br        = twd_pkg::branch_of(cur_item.char_code);
    br_ok     = (br != twd_pkg::NoBranch);
    br_idx    = br_ok ? br : '0;
    entry     = rd_row[br_idx];
    have      = (entry.child != '0);
    walk      = br_ok && !bad && !miss;
    alloc     = walk && !have && (cur_item.kind == twd_pkg::KIND_INSERT)
                && !next_free[twd_pkg::NodeW];
    full      = walk && !have && (cur_item.kind == twd_pkg::KIND_INSERT)
                && next_free[twd_pkg::NodeW];
    miss_set  = walk && !have && (cur_item.kind == twd_pkg::KIND_LOOKUP);
    moved     = walk && (have || alloc);
    reached   = have ? entry.child : next_free[twd_pkg::NodeW-1:0];
    ok_final  = cur_item.last_char && moved;
    mark      = ok_final && (cur_item.kind == twd_pkg::KIND_INSERT);
    row_we    = cmd.exec && (alloc || mark);
    entry_new.end_mark = mark ? 1'b1 : entry.end_mark;
    entry_new.child    = alloc ? next_free[twd_pkg::NodeW-1:0] : entry.child;
    row_new         = rd_row;
    row_new[br_idx] = entry_new;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      mem[clr_cnt] <= '0;
    end else if (row_we) begin
      mem[cursor] <= row_new;
    end
    if (cmd.rd_en) begin
      rd_row   <= mem[cursor];
      cur_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      cursor    <= '0;
      next_free <= twd_pkg::PoolW'(1);
      miss      <= 1'b0;
      bad       <= 1'b0;
      words     <= '0;
      done      <= 1'b0;
    end else begin
      done <= cmd.exec;
      if (cmd.clr_we) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.exec) begin
        if (alloc) begin
          next_free <= next_free + 1'b1;
        end
        if (mark && (words != '1)) begin
          words <= words + 1'b1;
        end
        if (cur_item.last_char) begin
          cursor <= '0;
          miss   <= 1'b0;
          bad    <= 1'b0;
        end else begin
          if (moved) cursor <= reached;
          miss <= miss || miss_set;
          bad  <= bad || !br_ok || full;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result.found <= ok_final && (cur_item.kind == twd_pkg::KIND_LOOKUP)
                      && have && entry.end_mark;
      result.status <= !br_ok ? twd_pkg::STATUS_BAD_CHAR :
                       full   ? twd_pkg::STATUS_POOL_FULL : twd_pkg::STATUS_OK;
      result.word_count <= (mark && (words != '1)) ? words + 1'b1 : words;
    end
  end

endmodule

@@ sv/trie_word_dictionary_top.sv @@
// Word dictionary kept as a 27-way trie: each transaction is one character of
// a word, marked lookup or insert, with a flag on the last character. Every
// accepted character gives exactly one result, shown for one cycle with done.
// The character and its node row are registered at the accept, then done and the
// result in the execute state; the result cannot be held off. Each character is
// a read and then a read-modify-write of one node row in the node memory; busy
// stays high until the row is written back. After reset, busy stays high for a
// clearing pass of all 4096 node rows, one row per cycle, before any input.
module trie_word_dictionary_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  twd_pkg::item_t    item,
  output logic              busy,
  output logic              done,
  output twd_pkg::result_t  result
);

  twd_pkg::ctrl_cmd_t cmd;
  twd_pkg::dp_stat_t  stat;

  twd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  twd_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted transaction gave no result two cycles later");

  a_no_back_to_back_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block took a transaction while one was in flight");

  a_found_is_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.found) |-> (result.status == twd_pkg::STATUS_OK))
    else $error("found reported together with an error status");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int      TIMEOUT_CYCLES = 600000;
  localparam int      RANDOM_ITEMS   = 2000;
  localparam int      FILL_CHARS     = 4200;
  localparam int      VOCAB_WORDS    = 48;
  localparam int      VOCAB_MAXLEN   = 8;
  localparam logic [7:0] LOWER_A     = 8'h61;
  localparam logic [7:0] LOWER_Z     = 8'h7A;
  localparam logic [7:0] CASE_BIT    = 8'h20;
  localparam logic [twd_pkg::CountW-1:0] COUNT_MAX = '1;

  typedef struct {
    twd_pkg::item_t it;
    bit             drain;
  } pending_t;

  logic             clk;
  logic             rst;
  logic             start;
  twd_pkg::item_t   item;
  logic             busy;
  logic             done;
  twd_pkg::result_t result;

  trie_word_dictionary_top uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // Private copy of the dictionary state.
  twd_pkg::node_t    kid_tab [twd_pkg::NodeCount*twd_pkg::AlphaSize];
  bit                word_end [twd_pkg::NodeCount];
  int                free_node;
  twd_pkg::node_t    cur_node;
  bit                missed;
  bit                abandoned;
  logic [twd_pkg::CountW-1:0] words_held;

  pending_t         pending[$];
  twd_pkg::result_t expected[$];

  logic [7:0] vocab_chr [VOCAB_WORDS][VOCAB_MAXLEN];
  int         vocab_len [VOCAB_WORDS];

  int  errors;
  int  n_sent;
  int  n_checked;
  int  n_found;
  int  n_bad;
  int  n_full;
  int  cycles;
  bit  hold;
  bit  go;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic int fold_branch(logic [7:0] c);
    logic [7:0] low;
    low = c | CASE_BIT;
    if (c == twd_pkg::ApostropheCode) return 26;
    if (low >= LOWER_A && low <= LOWER_Z) return int'(low - LOWER_A);
    return twd_pkg::AlphaSize;
  endfunction

  // Advances the dictionary by one character and returns what it reports.
  function automatic twd_pkg::result_t dict_step(twd_pkg::item_t it);
    twd_pkg::result_t r;
    int               br;
    int               slot;
    twd_pkg::node_t   kid;
    r  = '0;
    br = fold_branch(it.char_code);
    if (br == twd_pkg::AlphaSize) begin
      r.status  = twd_pkg::STATUS_BAD_CHAR;
      abandoned = 1'b1;
    end else if (!abandoned && !missed) begin
      slot = int'(cur_node) * twd_pkg::AlphaSize + br;
      kid  = kid_tab[slot];
      if (kid != '0) begin
        cur_node = kid;
      end else if (it.kind == twd_pkg::KIND_LOOKUP) begin
        missed = 1'b1;
      end else if (free_node < twd_pkg::NodeCount) begin
        kid = twd_pkg::node_t'(free_node);
        free_node++;
        for (int b = 0; b < twd_pkg::AlphaSize; b++)
          kid_tab[int'(kid) * twd_pkg::AlphaSize + b] = '0;
        word_end[kid] = 1'b0;
        kid_tab[slot] = kid;
        cur_node      = kid;
      end else begin
        r.status  = twd_pkg::STATUS_POOL_FULL;
        abandoned = 1'b1;
      end
    end
    if (it.last_char) begin
      if (!abandoned && !missed) begin
        if (it.kind == twd_pkg::KIND_INSERT) begin
          word_end[cur_node] = 1'b1;
          if (words_held != COUNT_MAX) words_held++;
        end else begin
          r.found = word_end[cur_node];
        end
      end
      cur_node  = '0;
      missed    = 1'b0;
      abandoned = 1'b0;
    end
    r.word_count = words_held;
    return r;
  endfunction

  function automatic logic [7:0] random_case(logic [7:0] c);
    if (c >= LOWER_A && c <= LOWER_Z && $urandom_range(1) == 1) return c & ~CASE_BIT;
    return c;
  endfunction

  function automatic logic [7:0] random_char();
    int b;
    b = $urandom_range(26);
    if (b == 26) return twd_pkg::ApostropheCode;
    return LOWER_A + 8'(b);
  endfunction

  task automatic push_char(logic kind, logic [7:0] code, logic last, bit drain = 1'b0);
    pending_t p;
    p.it.kind      = kind;
    p.it.char_code = code;
    p.it.last_char = last;
    p.drain        = drain;
    pending.push_back(p);
  endtask

  task automatic push_text(logic kind, string s);
    for (int i = 0; i < s.len(); i++) push_char(kind, s[i], i == s.len() - 1);
  endtask

  // Sends a stored word. mode 0 keeps it whole, 1 spoils one character with a
  // random byte, 2 gives every character a random kind.
  task automatic push_vocab(logic kind, int idx, int mode);
    int         spoil;
    logic [7:0] c;
    logic       k;
    spoil = $urandom_range(vocab_len[idx] - 1);
    for (int i = 0; i < vocab_len[idx]; i++) begin
      c = random_case(vocab_chr[idx][i]);
      k = kind;
      if (mode == 1 && i == spoil) c = 8'($urandom_range(255));
      if (mode == 2) k = 1'($urandom_range(1));
      push_char(k, c, i == vocab_len[idx] - 1);
    end
  endtask

  task automatic push_new_word(logic kind);
    int len;
    len = $urandom_range(7, 1);
    for (int i = 0; i < len; i++) push_char(kind, random_case(random_char()), i == len - 1);
  endtask

  task automatic push_group();
    int roll;
    int n;
    roll = $urandom_range(99);
    if (roll < 40) begin
      push_vocab(twd_pkg::KIND_INSERT, $urandom_range(VOCAB_WORDS - 1), 0);
    end else if (roll < 75) begin
      push_vocab(twd_pkg::KIND_LOOKUP, $urandom_range(VOCAB_WORDS - 1), 0);
    end else if (roll < 82) begin
      push_new_word(twd_pkg::KIND_LOOKUP);
    end else if (roll < 85) begin
      push_new_word(twd_pkg::KIND_INSERT);
    end else if (roll < 90) begin
      push_vocab(1'($urandom_range(1)), $urandom_range(VOCAB_WORDS - 1), 1);
    end else if (roll < 95) begin
      push_vocab(twd_pkg::KIND_LOOKUP, $urandom_range(VOCAB_WORDS - 1), 2);
    end else begin
      n = $urandom_range(4, 1);
      repeat (n) push_char(1'($urandom_range(1)), 8'($urandom_range(255)),
                           1'($urandom_range(1)));
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Driver: presents the head of the pending queue until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      item  <= '0;
    end else begin
      if (start && busy === 1'b0) begin
        void'(pending.pop_front());
        expected.push_back(dict_step(item));
        n_sent++;
      end
      hold = start && busy !== 1'b0;
      go   = hold;
      if (!hold && pending.size() != 0) begin
        go = 1'b1;
        if (pending[0].drain && expected.size() != 0) go = 1'b0;
        // A quiet window keeps characters back to back for a while.
        if (!(n_sent >= 700 && n_sent < 1100) && $urandom_range(99) < 32) go = 1'b0;
      end
      start <= go;
      if (go) item <= pending[0].it;
    end
  end

  // Monitor: every done transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual found=%0d status=%0d count=%0d",
                 $time, result.found, result.status, result.word_count);
      end else begin
        check_field("found", expected[0].found, result.found);
        check_field("status", expected[0].status, result.status);
        check_field("word_count", expected[0].word_count, result.word_count);
        n_checked++;
        if (expected[0].found) n_found++;
        if (expected[0].status == twd_pkg::STATUS_BAD_CHAR) n_bad++;
        if (expected[0].status == twd_pkg::STATUS_POOL_FULL) n_full++;
        void'(expected.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int target;
    errors     = 0;
    n_sent     = 0;
    n_checked  = 0;
    n_found    = 0;
    n_bad      = 0;
    n_full     = 0;
    cycles     = 0;
    free_node  = 1;
    cur_node   = '0;
    missed     = 1'b0;
    abandoned  = 1'b0;
    words_held = '0;
    for (int i = 0; i < twd_pkg::NodeCount * twd_pkg::AlphaSize; i++) kid_tab[i] = '0;
    for (int i = 0; i < twd_pkg::NodeCount; i++) word_end[i] = 1'b0;

    for (int w = 0; w < VOCAB_WORDS; w++) begin
      vocab_len[w] = $urandom_range(VOCAB_MAXLEN, 1);
      for (int i = 0; i < VOCAB_MAXLEN; i++) vocab_chr[w][i] = random_char();
    end

    // Directed words: alphabet edges, prefixes, misses, bad bytes, mixed kinds.
    push_text(twd_pkg::KIND_INSERT, "Az'");
    push_text(twd_pkg::KIND_LOOKUP, "aZ'");
    push_text(twd_pkg::KIND_LOOKUP, "aZ");
    push_text(twd_pkg::KIND_LOOKUP, "zq");
    push_text(twd_pkg::KIND_INSERT, "Az'");
    push_char(twd_pkg::KIND_INSERT, "a", 1'b0);
    push_char(twd_pkg::KIND_INSERT, 8'h00, 1'b0);
    push_char(twd_pkg::KIND_INSERT, "b", 1'b1);
    push_text(twd_pkg::KIND_LOOKUP, "ab");
    push_char(twd_pkg::KIND_LOOKUP, "q", 1'b0);
    push_char(twd_pkg::KIND_LOOKUP, 8'h40, 1'b0);
    push_char(twd_pkg::KIND_LOOKUP, 8'h5B, 1'b1);
    push_char(twd_pkg::KIND_LOOKUP, 8'h60, 1'b0);
    push_char(twd_pkg::KIND_LOOKUP, 8'h7B, 1'b0);
    push_char(twd_pkg::KIND_LOOKUP, 8'hFF, 1'b1);
    push_char(twd_pkg::KIND_LOOKUP, "M", 1'b0);
    push_char(twd_pkg::KIND_INSERT, "x", 1'b1);
    push_text(twd_pkg::KIND_LOOKUP, "mX");
    push_char(twd_pkg::KIND_LOOKUP, 8'h26, 1'b1);

    target = pending.size() + RANDOM_ITEMS;
    while (pending.size() < target) push_group();

    // One very long insert runs the node pool dry; the sender first waits for
    // every outstanding transaction.
    for (int i = 0; i < FILL_CHARS; i++)
      push_char(twd_pkg::KIND_INSERT, random_case(LOWER_A + 8'($urandom_range(25))),
                i == FILL_CHARS - 1, i == 0);
    repeat (40) push_group();

    while (pending.size() != 0 || expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d characters through the trie with %0d results checked.", n_sent, n_checked);
    $display("Seen: %0d words found, %0d bad characters, %0d pool-full refusals, %0d words held.",
             n_found, n_bad, n_full, words_held);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
